// ===== rtl/core/open_address_hash_table_unit_defines.svh =====
// ----------------------------------------------------------------------------
// open_address_hash_table_unit_defines
// assertion macros used by the hash table unit
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESS_HASH_TABLE_UNIT_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_UNIT_DEFINES_SVH

// same-cycle implication on clock, disabled in reset
`define OAHT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on clock, disabled in reset
`define OAHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// oaht_pkg
// types and codes of the open-addressing hash table
// ----------------------------------------------------------------------------
package oaht_pkg;

   localparam int KEY_W      = 64;
   localparam int DATA_W     = 64;
   localparam int TAG_W      = 2;
   localparam int CFG_W      = 9;
   localparam int COUNT_W    = 9;
   localparam int DIGIT_BITS = 4;
   localparam int DIGITS     = KEY_W / DIGIT_BITS;

   localparam logic [CFG_W-1:0] RESET_CAP = 9'd256;

   localparam logic ACT_FIND = 1'b0;
   localparam logic ACT_SET  = 1'b1;

   localparam logic [TAG_W-1:0] TAG_VALUE = 2'd0;
   localparam logic [TAG_W-1:0] TAG_NULL  = 2'd1;
   localparam logic [TAG_W-1:0] TAG_UNDEF = 2'd2;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_EMPTY = 2'd0;
   localparam kind_type KIND_TOMB  = 2'd1;
   localparam kind_type KIND_LIVE  = 2'd2;

   typedef struct packed {
      kind_type              kind;
      logic [KEY_W-1:0]      key;
      logic [DATA_W-1:0]     value;
   } slot_type;

endpackage

// ===== rtl/core/oaht_req_if.sv =====
// ----------------------------------------------------------------------------
// oaht_req_if
// request channel: action, key and value to store
// ----------------------------------------------------------------------------
interface oaht_req_if
   import oaht_pkg::*;
;
   logic              valid;
   logic              ready;
   logic              action;
   logic [KEY_W-1:0]  key;
   logic [TAG_W-1:0]  value_tag;
   logic [DATA_W-1:0] value_data;

   modport source (output valid, output action, output key, output value_tag,
                   output value_data, input ready);
   modport sink   (input valid, input action, input key, input value_tag,
                   input value_data, output ready);
endinterface

// ===== rtl/core/oaht_rsp_if.sv =====
// ----------------------------------------------------------------------------
// oaht_rsp_if
// response channel: lookup result, live count and overflow flag
// ----------------------------------------------------------------------------
interface oaht_rsp_if
   import oaht_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [TAG_W-1:0]   result_tag;
   logic [DATA_W-1:0]  result_data;
   logic [COUNT_W-1:0] live_count;
   logic               overflow;

   modport source (output valid, output result_tag, output result_data,
                   output live_count, output overflow, input ready);
   modport sink   (input valid, input result_tag, input result_data,
                   input live_count, input overflow, output ready);
endinterface

// ===== rtl/core/oaht_csr_if.sv =====
// ----------------------------------------------------------------------------
// oaht_csr_if
// configuration write channel for the active capacity
// ----------------------------------------------------------------------------
interface oaht_csr_if
   import oaht_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/oaht_ram.sv =====
// ----------------------------------------------------------------------------
// oaht_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module oaht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/oaht_mod_unit.sv =====
// ----------------------------------------------------------------------------
// oaht_mod_unit
// key modulo capacity, restoring reduction a few key bits per cycle
// ----------------------------------------------------------------------------
module oaht_mod_unit
   import oaht_pkg::*;
#(
   parameter int CAP_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   input  logic [CAP_W-1:0] cap,
   output logic             done,
   output logic [CAP_W-1:0] rem
);

   localparam int DCW = $clog2(DIGITS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DCW-1:0]   cnt_ff, cnt_in;
   logic [KEY_W-1:0] shift_ff, shift_in;
   logic [CAP_W-1:0] rem_ff, rem_in;
   logic [CAP_W-1:0] part;
   logic [CAP_W:0]   trial;

   // one digit of the key folded into the remainder
   always_comb begin
      part  = rem_ff;
      trial = '0;
      for (int i = 0; i < DIGIT_BITS; i++) begin
         trial = {part, shift_ff[KEY_W-1-i]};
         if (trial >= {1'b0, cap}) begin
            trial = trial - {1'b0, cap};
         end
         part = trial[CAP_W-1:0];
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = key;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = part;
         shift_in = shift_ff << DIGIT_BITS;
         cnt_in   = cnt_ff + DCW'(1);
         if (cnt_ff == DCW'(DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/core/open_address_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// open_address_hash_table_unit
// key/value table with linear probing and tombstones
// ----------------------------------------------------------------------------
// A request on req_bus is a find (action 0) or a set (action 1) of one key.
// A set with value_tag 0 inserts or overwrites; any other tag deletes the key
// and leaves a tombstone. Each request gives one response on rsp_bus with the
// lookup result, the live entry count after the request and an overflow flag
// for an insert that found no free slot. csr_bus writes the active capacity;
// it is always ready and should be written only while the table is idle.
// The table takes one request at a time. The home slot comes from a 64-bit
// key modulo capacity reduced four bits per cycle, then the probe walk reads
// one slot per cycle from the slot ram, for a walk of 1 to capacity probes.
// After reset a clearing pass marks every slot empty, one slot per cycle;
// req_bus is not ready meanwhile.
// The response sits in an output register: the next request is accepted while
// it waits, and a finished request waits in its commit step until the
// response register is free.
// ----------------------------------------------------------------------------
`include "open_address_hash_table_unit_defines.svh"

module open_address_hash_table_unit
   import oaht_pkg::*;
#(
   parameter int SLOTS = 256
) (
   input  logic       clock,
   input  logic       reset,
   oaht_req_if.sink   req_bus,
   oaht_rsp_if.source rsp_bus,
   oaht_csr_if.sink   csr_bus
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
   localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_MOD    = 3'd2;
   localparam logic [2:0] S_WALK   = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [IW-1:0]      clr_idx_ff, clr_idx_in;
   logic [CFG_W-1:0]   slots_in_use_ff, slots_in_use_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      steps_ff, steps_in;
   logic               tomb_seen_ff, tomb_seen_in;
   logic [IW-1:0]      first_tomb_ff, first_tomb_in;
   logic               matched_ff, matched_in;
   logic               have_ff, have_in;
   logic [IW-1:0]      slot_ff, slot_in;
   kind_type           slot_kind_ff, slot_kind_in;
   logic [DATA_W-1:0]  found_ff, found_in;
   logic               act_ff, act_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [DATA_W-1:0]  data_ff, data_in;
   logic [TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic [CW-1:0]      cap;
   logic               req_take;
   logic               mod_done;
   logic [CW-1:0]      mod_rem;

   logic               ram_wr_en;
   logic [IW-1:0]      ram_wr_addr;
   slot_type           ram_wr_data;
   logic [IW-1:0]      ram_rd_addr;
   slot_type           ram_rd_data;

   logic               hit_empty, hit_key, is_tomb, tomb_now, exhausted;
   logic [IW-1:0]      first_tomb_now, idx_next;
   logic [CW-1:0]      steps_next, idx_plus;

   logic               commit_go, commit_wr, commit_ovf;
   logic [CW-1:0]      commit_count;
   logic [TAG_W-1:0]   commit_tag;
   logic [DATA_W-1:0]  commit_data;
   slot_type           commit_slot;

   // active capacity, clamped to one .. SLOTS
   always_comb begin
      cap = CW'(slots_in_use_ff);
      if (cap == '0) begin
         cap = CW'(1);
      end
      if (cap > SLOTS_C) begin
         cap = SLOTS_C;
      end
   end

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;

   oaht_mod_unit #(
      .CAP_W(CW)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (req_take),
      .key   (req_bus.key),
      .cap   (cap),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   oaht_ram #(
      .WIDTH($bits(slot_type)),
      .DEPTH(SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // probe evaluation of the slot read last cycle
   always_comb begin
      hit_empty      = (ram_rd_data.kind == KIND_EMPTY);
      hit_key        = !hit_empty && (ram_rd_data.key == key_ff);
      is_tomb        = (ram_rd_data.kind == KIND_TOMB);
      tomb_now       = tomb_seen_ff || is_tomb;
      first_tomb_now = tomb_seen_ff ? first_tomb_ff : idx_ff;
      steps_next     = steps_ff + CW'(1);
      exhausted      = (steps_next == cap);
      idx_plus       = CW'(idx_ff) + CW'(1);
      idx_next       = (idx_plus >= cap) ? '0 : idx_plus[IW-1:0];
   end

   // commit outcome
   always_comb begin
      commit_go         = (state_ff == S_COMMIT) && (!rsp_valid_ff || rsp_bus.ready);
      commit_wr         = 1'b0;
      commit_ovf        = 1'b0;
      commit_count      = count_ff;
      commit_tag        = TAG_VALUE;
      commit_data       = '0;
      commit_slot.kind  = KIND_LIVE;
      commit_slot.key   = key_ff;
      commit_slot.value = data_ff;
      if (act_ff == ACT_FIND) begin
         if (matched_ff && (slot_kind_ff == KIND_LIVE)) begin
            commit_data = found_ff;
         end else begin
            commit_tag = TAG_UNDEF;
         end
      end else if (tag_ff == TAG_VALUE) begin
         if (!have_ff) begin
            commit_ovf = 1'b1;
         end else if (slot_kind_ff != KIND_LIVE) begin
            if (count_ff >= cap) begin
               commit_ovf = 1'b1;
            end else begin
               commit_count = count_ff + CW'(1);
               commit_wr    = 1'b1;
            end
         end else begin
            commit_wr = 1'b1;
         end
      end else if (have_ff) begin
         if ((slot_kind_ff == KIND_LIVE) && (count_ff != '0)) begin
            commit_count = count_ff - CW'(1);
         end
         commit_wr         = 1'b1;
         commit_slot.kind  = KIND_TOMB;
         commit_slot.value = '0;
      end
   end

   always_comb begin
      state_in        = state_ff;
      clr_idx_in      = clr_idx_ff;
      slots_in_use_in = slots_in_use_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      idx_in          = idx_ff;
      steps_in        = steps_ff;
      tomb_seen_in    = tomb_seen_ff;
      first_tomb_in   = first_tomb_ff;
      matched_in      = matched_ff;
      have_in         = have_ff;
      slot_in         = slot_ff;
      slot_kind_in    = slot_kind_ff;
      found_in        = found_ff;
      act_in          = act_ff;
      key_in          = key_ff;
      tag_in          = tag_ff;
      data_in         = data_ff;
      rsp_tag_in      = rsp_tag_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_ovf_in      = rsp_ovf_ff;

      ram_rd_addr       = idx_ff;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = clr_idx_ff;
      ram_wr_data.kind  = KIND_EMPTY;
      ram_wr_data.key   = '0;
      ram_wr_data.value = '0;

      if (csr_bus.valid && csr_bus.ready) begin
         slots_in_use_in = csr_bus.data;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en  = 1'b1;
            clr_idx_in = clr_idx_ff + IW'(1);
            if (clr_idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               act_in   = req_bus.action;
               key_in   = req_bus.key;
               tag_in   = req_bus.value_tag;
               data_in  = req_bus.value_data;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               ram_rd_addr  = mod_rem[IW-1:0];
               idx_in       = mod_rem[IW-1:0];
               steps_in     = '0;
               tomb_seen_in = 1'b0;
               state_in     = S_WALK;
            end
         end
         S_WALK: begin
            found_in = ram_rd_data.value;
            if (hit_empty || hit_key) begin
               matched_in = hit_key;
               have_in    = 1'b1;
               if (hit_key) begin
                  slot_in      = idx_ff;
                  slot_kind_in = ram_rd_data.kind;
               end else if (tomb_seen_ff) begin
                  slot_in      = first_tomb_ff;
                  slot_kind_in = KIND_TOMB;
               end else begin
                  slot_in      = idx_ff;
                  slot_kind_in = KIND_EMPTY;
               end
               state_in = S_COMMIT;
            end else if (exhausted) begin
               matched_in   = 1'b0;
               have_in      = tomb_now;
               slot_in      = first_tomb_now;
               slot_kind_in = KIND_TOMB;
               state_in     = S_COMMIT;
            end else begin
               tomb_seen_in  = tomb_now;
               first_tomb_in = first_tomb_now;
               steps_in      = steps_next;
               idx_in        = idx_next;
               ram_rd_addr   = idx_next;
            end
         end
         S_COMMIT: begin
            if (commit_go) begin
               ram_wr_en    = commit_wr;
               ram_wr_addr  = slot_ff;
               ram_wr_data  = commit_slot;
               count_in     = commit_count;
               rsp_valid_in = 1'b1;
               rsp_tag_in   = commit_tag;
               rsp_data_in  = commit_data;
               rsp_count_in = COUNT_W'(commit_count);
               rsp_ovf_in   = commit_ovf;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_idx_ff      <= '0;
         slots_in_use_ff <= RESET_CAP;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_idx_ff      <= clr_idx_in;
         slots_in_use_ff <= slots_in_use_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      steps_ff      <= steps_in;
      tomb_seen_ff  <= tomb_seen_in;
      first_tomb_ff <= first_tomb_in;
      matched_ff    <= matched_in;
      have_ff       <= have_in;
      slot_ff       <= slot_in;
      slot_kind_ff  <= slot_kind_in;
      found_ff      <= found_in;
      act_ff        <= act_in;
      key_ff        <= key_in;
      tag_ff        <= tag_in;
      data_ff       <= data_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_tag  = rsp_tag_ff;
   assign rsp_bus.result_data = rsp_data_ff;
   assign rsp_bus.live_count  = rsp_count_ff;
   assign rsp_bus.overflow    = rsp_ovf_ff;

   `OAHT_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= SLOTS_C, "live count above table size")
   `OAHT_ASSERT_IMP(a_mod_done_in_mod, mod_done, state_ff == S_MOD, "modulo done outside modulo step")
   `OAHT_ASSERT_IMP(a_clear_blocks_req, state_ff == S_CLEAR, !req_bus.ready, "request taken during clear")
   `OAHT_ASSERT_NEXT(a_take_starts_mod, req_take, state_ff == S_MOD, "request did not start modulo")

endmodule

// ===== tb/open_address_hash_table_unit_test.sv =====
// ----------------------------------------------------------------------------
// open_address_hash_table_unit_test
// Drives find and set requests into the linear-probing hash table. A shadow
// copy of the slot store predicts each response, and every response is
// checked field by field against it. The run covers directed corner cases,
// capacity extremes and a long output stall, then random traffic over small
// key pools under several capacities and idle patterns.
// ----------------------------------------------------------------------------
module open_address_hash_table_unit_test;
   import oaht_pkg::*;

   localparam int TABLE_SLOTS = 256;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_CYCLES = 300;
   localparam int PRINT_LIMIT = 40;
   localparam logic [TAG_W-1:0] TAG_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] live_count;
      logic               overflow;
   } table_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   oaht_req_if req_bus ();
   oaht_rsp_if rsp_bus ();
   oaht_csr_if csr_bus ();

   open_address_hash_table_unit #(.SLOTS(TABLE_SLOTS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   kind_type          shadow_kind [TABLE_SLOTS] = '{default: KIND_EMPTY};
   logic [KEY_W-1:0]  shadow_key [TABLE_SLOTS] = '{default: '0};
   logic [DATA_W-1:0] shadow_value [TABLE_SLOTS] = '{default: '0};
   int unsigned       shadow_live_count = 0;
   logic [CFG_W-1:0]  capacity_setting = RESET_CAP;

   table_response_type pending_responses[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap_pct = 26;
   int unsigned rsp_stall_pct = 80;
   int unsigned rsp_hold_cycles = 0;

   always #6 clock = ~clock;

   function automatic int unsigned active_slots();
      if (capacity_setting == '0) return 1;
      if (capacity_setting > TABLE_SLOTS) return TABLE_SLOTS;
      return capacity_setting;
   endfunction

   function automatic table_response_type predict_response(logic act, logic [KEY_W-1:0] key,
                                                            logic [TAG_W-1:0] tag,
                                                            logic [DATA_W-1:0] data);
      int unsigned cap, idx, first_tomb, slot;
      bit stopped, matched, tomb_seen, have;
      table_response_type r;
      cap = active_slots();
      idx = int'(key % 64'(cap));
      stopped = 0;
      matched = 0;
      tomb_seen = 0;
      first_tomb = 0;
      r = '0;
      for (int step = 0; step < cap; step++) begin
         if (shadow_kind[idx] == KIND_EMPTY) begin
            stopped = 1;
            break;
         end
         if (shadow_key[idx] == key) begin
            stopped = 1;
            matched = 1;
            break;
         end
         if (shadow_kind[idx] == KIND_TOMB && !tomb_seen) begin
            tomb_seen = 1;
            first_tomb = idx;
         end
         idx = (idx + 1 >= cap) ? 0 : idx + 1;
      end
      if (act == ACT_FIND) begin
         if (matched && shadow_kind[idx] == KIND_LIVE) begin
            r.tag = TAG_VALUE;
            r.data = shadow_value[idx];
         end else begin
            r.tag = TAG_UNDEF;
         end
      end else begin
         have = 1;
         slot = 0;
         if (matched) slot = idx;
         else if (tomb_seen) slot = first_tomb;
         else if (stopped) slot = idx;
         else have = 0;
         if (tag == TAG_VALUE) begin
            if (!have) begin
               r.overflow = 1'b1;
            end else if (shadow_kind[slot] != KIND_LIVE) begin
               if (shadow_live_count >= cap) begin
                  r.overflow = 1'b1;
               end else begin
                  shadow_live_count++;
                  shadow_kind[slot] = KIND_LIVE;
                  shadow_key[slot] = key;
                  shadow_value[slot] = data;
               end
            end else begin
               shadow_key[slot] = key;
               shadow_value[slot] = data;
            end
         end else if (have) begin
            if (shadow_kind[slot] == KIND_LIVE && shadow_live_count > 0) shadow_live_count--;
            shadow_kind[slot] = KIND_TOMB;
            shadow_key[slot] = key;
            shadow_value[slot] = '0;
         end
      end
      r.live_count = COUNT_W'(shadow_live_count);
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch on %s: got %0h, expected %0h", field, got, want);
      mismatch_count++;
   endtask

   task automatic send_request(logic act, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                               logic [DATA_W-1:0] data);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.key <= key;
      req_bus.value_tag <= tag;
      req_bus.value_data <= data;
      do @(posedge clock); while (!req_bus.ready);
      pending_responses.push_back(predict_response(act, key, tag, data));
   endtask

   task automatic wait_for_idle();
      req_bus.valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_capacity(logic [CFG_W-1:0] setting);
      wait_for_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.data <= setting;
      do @(posedge clock); while (!csr_bus.ready);
      capacity_setting = setting;
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [TAG_W-1:0] pick_delete_tag();
      case ($urandom_range(2))
         0: return TAG_NULL;
         1: return TAG_UNDEF;
         default: return TAG_UNKNOWN;
      endcase
   endfunction

   task automatic test_find_insert_delete();
      logic [KEY_W-1:0] max_key;
      max_key = '1;
      send_request(ACT_FIND, 64'd0, TAG_VALUE, '0);
      send_request(ACT_SET, 64'd0, TAG_VALUE, '1);
      send_request(ACT_SET, max_key, TAG_VALUE, '0);
      send_request(ACT_SET, 64'd256, TAG_VALUE, 64'h5a5a_a5a5_0f0f_f0f0);
      send_request(ACT_FIND, 64'd256, TAG_UNKNOWN, '1);
      send_request(ACT_FIND, max_key, TAG_VALUE, '0);
      send_request(ACT_SET, 64'd0, TAG_VALUE, 64'd1);
      send_request(ACT_SET, 64'd0, TAG_NULL, '1);
      send_request(ACT_FIND, 64'd256, TAG_VALUE, '0);
      send_request(ACT_FIND, 64'd0, TAG_VALUE, '0);
      send_request(ACT_SET, 64'd512, TAG_VALUE, 64'h8000_0000_0000_0001);
      send_request(ACT_SET, 64'd256, TAG_UNDEF, '0);
      send_request(ACT_SET, 64'd512, TAG_UNKNOWN, '0);
      send_request(ACT_SET, 64'd768, TAG_NULL, '0);
   endtask

   task automatic test_capacity_extremes();
      write_capacity('0);
      send_request(ACT_SET, 64'd5, TAG_VALUE, 64'hdead_beef_cafe_f00d);
      send_request(ACT_FIND, 64'd5, TAG_VALUE, '0);
      write_capacity('1);
      send_request(ACT_SET, '1, TAG_NULL, '0);
      write_capacity(9'd1);
      send_request(ACT_SET, 64'd9, TAG_VALUE, 64'h0123_4567_89ab_cdef);
      send_request(ACT_SET, 64'd10, TAG_VALUE, 64'd7);
      send_request(ACT_SET, 64'd10, TAG_NULL, '0);
      send_request(ACT_FIND, 64'd9, TAG_VALUE, '0);
      send_request(ACT_SET, 64'd9, TAG_UNKNOWN, '0);
   endtask

   task automatic test_output_backpressure();
      int unsigned saved_gap;
      write_capacity(9'd8);
      saved_gap = send_gap_pct;
      send_gap_pct = 0;
      rsp_hold_cycles = 300;
      for (int i = 0; i < 12; i++)
         send_request((i % 3 == 2) ? ACT_FIND : ACT_SET, 64'($urandom_range(23)),
                      TAG_VALUE, {$urandom, $urandom});
      send_gap_pct = saved_gap;
   endtask

   task automatic run_random_phase(logic [CFG_W-1:0] setting, int unsigned n_items);
      logic [KEY_W-1:0] pool[$];
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic act;
      int unsigned cap, pool_size, roll;
      write_capacity(setting);
      cap = active_slots();
      pool_size = (cap * 2 < 40) ? cap * 2 + 2 : 42;
      for (int i = 0; i < pool_size; i++) begin
         roll = $urandom_range(2);
         if (i > 0 && roll == 0)
            pool.push_back(pool[$urandom_range(i - 1)] + 64'(cap) * $urandom_range(1, 3));
         else if (roll == 1)
            pool.push_back(64'($urandom_range(cap * 3)));
         else
            pool.push_back({$urandom, $urandom});
      end
      for (int i = 0; i < n_items; i++) begin
         roll = $urandom_range(99);
         key = ($urandom_range(99) < 5) ? {$urandom, $urandom} :
               pool[$urandom_range(pool.size() - 1)];
         act = (roll < 40) ? ACT_FIND : ACT_SET;
         if (act == ACT_FIND) tag = TAG_W'($urandom);
         else if (roll >= 82) tag = pick_delete_tag();
         else tag = TAG_VALUE;
         send_request(act, key, tag, {$urandom, $urandom});
      end
      foreach (pool[i]) send_request(ACT_SET, pool[i], pick_delete_tag(), {$urandom, $urandom});
   endtask

   task automatic test_random_traffic();
      logic [CFG_W-1:0] phase_caps [9] = '{9'd5, 9'd1, 9'd16, 9'd0, 9'd64, 9'd3,
                                           9'd256, 9'd511, 9'd32};
      int unsigned phase_items [9] = '{120, 50, 200, 30, 250, 120, 90, 50, 240};
      for (int p = 0; p < 9; p++) begin
         if (p < 3) begin
            send_gap_pct = 26;
            rsp_stall_pct = 80;
         end else if (p < 6) begin
            send_gap_pct = 80;
            rsp_stall_pct = 26;
         end else begin
            send_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         run_random_phase(phase_caps[p], phase_items[p]);
      end
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_responses
      table_response_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response with no request pending", rsp_bus.result_data, '0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_bus.result_tag !== want.tag)
               report_mismatch("result_tag", 64'(rsp_bus.result_tag), 64'(want.tag));
            if (rsp_bus.result_data !== want.data)
               report_mismatch("result_data", rsp_bus.result_data, want.data);
            if (rsp_bus.live_count !== want.live_count)
               report_mismatch("live_count", 64'(rsp_bus.live_count), 64'(want.live_count));
            if (rsp_bus.overflow !== want.overflow)
               report_mismatch("overflow", 64'(rsp_bus.overflow), 64'(want.overflow));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("open_address_hash_table_unit_test: FAIL");
      $finish;
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.action <= ACT_FIND;
      req_bus.key <= '0;
      req_bus.value_tag <= TAG_VALUE;
      req_bus.value_data <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.data <= RESET_CAP;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_find_insert_delete();
      test_capacity_extremes();
      test_output_backpressure();
      test_random_traffic();
      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("open_address_hash_table_unit_test: PASS");
      else
         $display("open_address_hash_table_unit_test: FAIL");
      $finish;
   end

endmodule
